@@ rtl/ssdiv_pkg.sv @@
// shared types and constants for the signed shift-subtract divider
package ssdiv_pkg;

    localparam int DATA_W = 32;

    typedef logic [DATA_W-1:0] t_word;

    // largest positive quotient, used when a positive magnitude overflows
    localparam t_word QUOT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // payload carried from one divide stage to the next
    typedef struct packed {
        t_word rem;  // partial remainder
        t_word nq;   // dividend bits still to use on top, quotient bits below
        t_word den;  // divisor magnitude
        logic  neg;  // quotient is negative
        logic  dbz;  // divisor was zero
    } t_div_stage;

endpackage

@@ rtl/ssdiv_stage.sv @@
// one restoring divide step with its pipeline register
module ssdiv_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_valid,
    input  ssdiv_pkg::t_div_stage i_data,
    output logic                  o_valid,
    output ssdiv_pkg::t_div_stage o_data
);

    logic                  r_valid;
    ssdiv_pkg::t_div_stage r_data;
    ssdiv_pkg::t_div_stage n_data;
    logic [ssdiv_pkg::DATA_W:0]   w_trial;
    logic [ssdiv_pkg::DATA_W:0]   w_diff;
    logic                         w_ge;

    // bring down the next dividend bit and try the subtract
    assign w_trial = {i_data.rem, i_data.nq[ssdiv_pkg::DATA_W-1]};
    assign w_diff  = w_trial - {1'b0, i_data.den};
    assign w_ge    = ~w_diff[ssdiv_pkg::DATA_W];

    always_comb begin
        n_data     = i_data;
        n_data.rem = w_ge ? w_diff[ssdiv_pkg::DATA_W-1:0] : w_trial[ssdiv_pkg::DATA_W-1:0];
        n_data.nq  = {i_data.nq[ssdiv_pkg::DATA_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ rtl/signed_shift_subtract_divider_unit.sv @@
// top level of the pipelined signed shift-subtract divider
//
// input channel: i_valid with i_dividend_value and i_divisor_value; the item is
// taken at a clock edge where i_valid is high and o_stall is low.
// output channel: o_valid with o_quotient and o_divide_by_zero; the item is
// taken at a clock edge where o_valid is high and i_stall is low.
// the quotient is truncated toward zero; a positive quotient that does not fit
// saturates to the largest positive value; a zero divisor gives quotient 0 with
// o_divide_by_zero set.
// the operand magnitudes are formed into an input register, each of a chain of
// DATA_W subtract stages registers one quotient bit, and the sign is applied
// into the output register. while the receiver does not stall, one item can
// enter every cycle, so sustained throughput is one item per cycle.
// when the receiver stalls a waiting result the whole pipeline holds and
// o_stall rises; nothing is dropped or repeated.
// synchronous reset clears all valid bits; no item is in flight afterwards.
module signed_shift_subtract_divider_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [ssdiv_pkg::DATA_W-1:0] i_dividend_value,
    input  logic signed [ssdiv_pkg::DATA_W-1:0] i_divisor_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [ssdiv_pkg::DATA_W-1:0] o_quotient,
    output logic                                o_divide_by_zero
);

    localparam int W = ssdiv_pkg::DATA_W;

    logic                  w_adv;
    ssdiv_pkg::t_word      w_a;
    ssdiv_pkg::t_word      w_b;
    ssdiv_pkg::t_div_stage n_in;
    ssdiv_pkg::t_div_stage r_in;
    logic                  r_in_valid;
    logic                  w_valid [0:W];
    ssdiv_pkg::t_div_stage w_data  [0:W];
    ssdiv_pkg::t_word      n_quotient;
    ssdiv_pkg::t_word      w_q;
    logic                  r_out_valid;
    ssdiv_pkg::t_word      r_quotient;
    logic                  r_dbz;

    // pipeline moves unless a finished result is held by the receiver
    assign w_adv   = ~(r_out_valid & i_stall);
    assign o_stall = ~w_adv;

    assign w_a = ssdiv_pkg::t_word'(i_dividend_value);
    assign w_b = ssdiv_pkg::t_word'(i_divisor_value);

    always_comb begin
        n_in.rem = '0;
        n_in.nq  = w_a[W-1] ? (~w_a + 1'b1) : w_a;
        n_in.den = w_b[W-1] ? (~w_b + 1'b1) : w_b;
        n_in.neg = w_a[W-1] ^ w_b[W-1];
        n_in.dbz = (w_b == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in <= n_in;
        end
    end

    assign w_valid[0] = r_in_valid;
    assign w_data[0]  = r_in;

    for (genvar g = 0; g < W; g++) begin : g_stage
        ssdiv_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_valid[g]),
            .i_data  (w_data[g]),
            .o_valid (w_valid[g+1]),
            .o_data  (w_data[g+1])
        );
    end

    // sign, saturation and zero divisor
    assign w_q = w_data[W].nq;

    always_comb begin
        if (w_data[W].dbz) begin
            n_quotient = '0;
        end else if (w_data[W].neg) begin
            n_quotient = ~w_q + 1'b1;
        end else if (w_q[W-1]) begin
            n_quotient = ssdiv_pkg::QUOT_MAX;
        end else begin
            n_quotient = w_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_valid[W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_quotient <= n_quotient;
            r_dbz      <= w_data[W].dbz;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_quotient       = $signed(r_quotient);
    assign o_divide_by_zero = r_dbz;

`ifndef SYNTH
    a_dbz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dbz) |-> (r_quotient == '0))
        else $error("zero divisor result with nonzero quotient");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> ($stable(r_in_valid) && $stable(w_valid[W])))
        else $error("pipeline moved while result was stalled");

    a_zero_den_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_valid[W] && !w_data[W].dbz) |-> (w_data[W].den != '0))
        else $error("zero divisor reached the end without its flag");
`endif

endmodule
